// ----- rtl/gbi_pkg.sv -----
// shared constants, codes and helpers of the grid bilinear interpolation unit
`default_nettype none
package gbi_pkg;

  // grid store geometry
  localparam int MAX_COLS   = 64;
  localparam int MAX_ROWS   = 64;
  localparam int VALUE_BITS = 32;
  localparam int COL_BITS   = $clog2(MAX_COLS);
  localparam int ROW_BITS   = $clog2(MAX_ROWS);
  // four banks split by row and column parity
  localparam int BANK_DEPTH = (MAX_COLS / 2) * (MAX_ROWS / 2);

  // request codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OUTSIDE = 2'd1;
  localparam logic [1:0] ST_WRITE   = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_INV_X    = 3'd2;
  localparam logic [2:0] REG_INV_Y    = 3'd3;
  localparam logic [2:0] REG_COLS     = 3'd4;
  localparam logic [2:0] REG_ROWS     = 3'd5;

  // clip to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
    logic signed [31:0] r;
    if (v > 80'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -80'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // clip an incoming sample to the stored width
  function automatic logic signed [VALUE_BITS-1:0] sat_sample(input logic signed [31:0] s);
    logic signed [48:0] e;
    logic signed [48:0] hi;
    logic signed [VALUE_BITS-1:0] r;
    e  = 49'(s);
    hi = (49'sd1 <<< (VALUE_BITS - 1)) - 49'sd1;
    if (e > hi) begin
      r = hi[VALUE_BITS-1:0];
    end else if (e < -hi - 49'sd1) begin
      r = VALUE_BITS'(-hi - 49'sd1);
    end else begin
      r = e[VALUE_BITS-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/gbi_ram.sv -----
// generic single-write, single-read ram with registered read data
`default_nettype none
module gbi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/grid_bilinear_interpolation_unit.sv -----
// top level: banked grid store and bilinear interpolation pipeline
// Takes one request (sample write or point query) every cycle; busy is never
// raised. Each request gives one result on done, in request order. The
// receiver cannot stall, so done is a one-cycle strobe that must be taken when
// it appears. Each request passes through the pipeline steps: offset,
// coordinate scaling, cell locate and bank read, corner weighting, row blend,
// column blend and slope scaling, final slope scaling. The grid lives in four
// memories split by row and column parity, so the four corners of a cell are
// read in the same cycle. A sample write lands in its bank from the stage 2
// registers, before any later query reads. Unwritten entries read as garbage.
`default_nettype none
module grid_bilinear_interpolation_unit import gbi_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               req_type,
  input  wire logic [5:0]         col_index,
  input  wire logic [5:0]         row_index,
  input  wire logic signed [31:0] sample_value,
  input  wire logic signed [31:0] query_x,
  input  wire logic signed [31:0] query_y,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  output logic                    done,
  output logic signed [31:0]      interp_value,
  output logic signed [31:0]      slope_x,
  output logic signed [31:0]      slope_y,
  output logic [1:0]              status
);

  localparam int SW = VALUE_BITS;
  localparam int DW = SW + 1;
  localparam int WW = 18;
  localparam int PW = DW + WW + 1;
  localparam int FW = PW - 16;
  localparam int QW = FW + WW + 1;
  localparam int XW = FW + 32;
  localparam int YW = FW + 33;
  localparam int AW = $clog2(BANK_DEPTH);
  localparam logic signed [WW-1:0] Q_ONE  = WW'(65536);
  localparam logic signed [PW-1:0] HALF_P = PW'(32768);
  localparam logic signed [QW-1:0] HALF_Q = QW'(32768);
  localparam logic signed [XW-1:0] HALF_X = XW'(32768);
  localparam logic signed [YW-1:0] HALF_Y = YW'(32768);

  // configuration registers
  logic signed [31:0] origin_x, origin_y;
  logic [30:0]        inv_step_x, inv_step_y;
  logic [6:0]         cols_in_use, rows_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x    <= '0;
      origin_y    <= '0;
      inv_step_x  <= 31'd65536;
      inv_step_y  <= 31'd65536;
      cols_in_use <= 7'd64;
      rows_in_use <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X: origin_x    <= cfg_data;
        REG_ORIGIN_Y: origin_y    <= cfg_data;
        REG_INV_X:    inv_step_x  <= cfg_data[30:0];
        REG_INV_Y:    inv_step_y  <= cfg_data[30:0];
        REG_COLS:     cols_in_use <= cfg_data[6:0];
        REG_ROWS:     rows_in_use <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // pipeline control
  logic [7:1] vld;
  logic [7:1] typ;
  logic [7:3] ok;

  // stage 1: offsets and write fields
  logic signed [32:0]     dx1, dy1;
  logic [5:0]             col1, row1;
  logic signed [SW-1:0]   smp1;
  // stage 2: grid coordinates
  logic signed [63:0]     tx2, ty2;
  logic [5:0]             col2, row2;
  logic signed [SW-1:0]   smp2;
  // stage 3: weights and bank routing
  logic [16:0]            wx3, wy3;
  logic                   ix0_3, iy0_3;
  // stage 4: weighted corners
  logic signed [PW-1:0]   p00, p10, p01, p11, dl4, dh4;
  logic [16:0]            wy4, wy5;
  // stage 5: row blend
  logic signed [FW-1:0]   flo5, fhi5, d5;
  // stage 6: column blend products
  logic signed [QW-1:0]   qlo6, qhi6;
  logic signed [XW-1:0]   sxp6;
  logic signed [FW:0]     fd6;
  // stage 7
  logic signed [31:0]     val7, sx7;
  logic signed [YW-1:0]   syp7;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[6:1], start & ~busy};
    end
  end

  always_ff @(posedge clk) begin
    typ <= {typ[6:1], req_type};
  end

  // stage 1 registers
  always_ff @(posedge clk) begin
    dx1  <= 33'(query_x) - 33'(origin_x);
    dy1  <= 33'(query_y) - 33'(origin_y);
    col1 <= col_index;
    row1 <= row_index;
    smp1 <= sat_sample(sample_value);
  end

  // stage 2 registers: scale to grid units
  always_ff @(posedge clk) begin
    tx2  <= dx1 * $signed({1'b0, inv_step_x});
    ty2  <= dy1 * $signed({1'b0, inv_step_y});
    col2 <= col1;
    row2 <= row1;
    smp2 <= smp1;
  end

  // locate the cell on each axis
  logic [6:0]          ncols, nrows;
  logic [30:0]         ix_raw, iy_raw;
  logic                okx, oky, lastx, lasty;
  logic [COL_BITS-1:0] ix;
  logic [ROW_BITS-1:0] iy;
  logic [16:0]         wx, wy;

  always_comb begin
    ncols = (cols_in_use < 7'd2) ? 7'd2 :
            (cols_in_use > 7'(MAX_COLS)) ? 7'(MAX_COLS) : cols_in_use;
    nrows = (rows_in_use < 7'd2) ? 7'd2 :
            (rows_in_use > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : rows_in_use;
    ix_raw = tx2[62:32];
    iy_raw = ty2[62:32];
    okx    = ~tx2[63] && (ix_raw < 31'(ncols));
    oky    = ~ty2[63] && (iy_raw < 31'(nrows));
    lastx  = ix_raw == 31'(ncols - 7'd1);
    lasty  = iy_raw == 31'(nrows - 7'd1);
    ix     = lastx ? COL_BITS'(ix_raw - 31'd1) : COL_BITS'(ix_raw);
    iy     = lasty ? ROW_BITS'(iy_raw - 31'd1) : ROW_BITS'(iy_raw);
    wx     = {lastx, tx2[31:16]};
    wy     = {lasty, ty2[31:16]};
  end

  always_ff @(posedge clk) begin
    ok[3]   <= okx & oky;
    ok[7:4] <= ok[6:3];
    wx3     <= wx;
    wy3     <= wy;
    ix0_3   <= ix[0];
    iy0_3   <= iy[0];
  end

  // four parity banks: bank index is {row parity, column parity}
  logic [SW-1:0] rd [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic [1:0] BSEL = 2'(b);
    logic [ROW_BITS-1:0] rsel;
    logic [COL_BITS-1:0] csel;
    logic                bwe;
    assign rsel = (iy[0] == BSEL[1]) ? iy : iy + ROW_BITS'(1);
    assign csel = (ix[0] == BSEL[0]) ? ix : ix + COL_BITS'(1);
    assign bwe  = vld[2] && (typ[2] == REQ_WRITE) &&
                  (row2[0] == BSEL[1]) && (col2[0] == BSEL[0]);
    gbi_ram #(.WIDTH(SW), .DEPTH(BANK_DEPTH)) u_bank (
      .clk   (clk),
      .we    (bwe),
      .waddr (AW'({row2[ROW_BITS-1:1], col2[COL_BITS-1:1]})),
      .wdata (smp2),
      .raddr ({rsel[ROW_BITS-1:1], csel[COL_BITS-1:1]}),
      .rdata (rd[b])
    );
  end

  // stage 4: weight corners and column differences
  logic signed [SW-1:0] s00, s10, s01, s11;
  logic signed [WW-1:0] wnx, wpx, wny, wpy;

  always_comb begin
    s00 = rd[{iy0_3, ix0_3}];
    s10 = rd[{iy0_3, ~ix0_3}];
    s01 = rd[{~iy0_3, ix0_3}];
    s11 = rd[{~iy0_3, ~ix0_3}];
    wpx = $signed({1'b0, wx3});
    wpy = $signed({1'b0, wy3});
    wnx = Q_ONE - wpx;
    wny = Q_ONE - wpy;
  end

  always_ff @(posedge clk) begin
    p00 <= s00 * wnx;
    p10 <= s10 * wpx;
    p01 <= s01 * wnx;
    p11 <= s11 * wpx;
    dl4 <= (DW'(s10) - DW'(s00)) * wny;
    dh4 <= (DW'(s11) - DW'(s01)) * wpy;
    wy4 <= wy3;
  end

  // stage 5: round the row blends and the x difference
  logic signed [PW-1:0] sum_lo, sum_hi, sum_d;

  always_comb begin
    sum_lo = p00 + p10 + HALF_P;
    sum_hi = p01 + p11 + HALF_P;
    sum_d  = dl4 + dh4 + HALF_P;
  end

  always_ff @(posedge clk) begin
    flo5 <= sum_lo[PW-1:16];
    fhi5 <= sum_hi[PW-1:16];
    d5   <= sum_d[PW-1:16];
    wy5  <= wy4;
  end

  // stage 6: column blend products and x slope product
  logic signed [WW-1:0] wpy5, wny5;

  always_comb begin
    wpy5 = $signed({1'b0, wy5});
    wny5 = Q_ONE - wpy5;
  end

  always_ff @(posedge clk) begin
    qlo6 <= flo5 * wny5;
    qhi6 <= fhi5 * wpy5;
    sxp6 <= d5 * $signed({1'b0, inv_step_x});
    fd6  <= (FW + 1)'(fhi5) - (FW + 1)'(flo5);
  end

  // stage 7: value and x slope, y slope product
  logic signed [QW-1:0] vsum;
  logic signed [XW-1:0] xsum;

  always_comb begin
    vsum = qlo6 + qhi6 + HALF_Q;
    xsum = sxp6 + HALF_X;
  end

  always_ff @(posedge clk) begin
    val7 <= sat32(80'($signed(vsum[QW-1:16])));
    sx7  <= sat32(80'($signed(xsum[XW-1:16])));
    syp7 <= fd6 * $signed({1'b0, inv_step_y});
  end

  // stage 8: result register
  logic signed [YW-1:0] ysum;
  logic                 query_ok;

  always_comb begin
    ysum     = syp7 + HALF_Y;
    query_ok = (typ[7] == REQ_QUERY) && ok[7];
  end

  always_ff @(posedge clk) begin
    done         <= vld[7] & ~rst;
    interp_value <= query_ok ? val7 : '0;
    slope_x      <= query_ok ? sx7 : '0;
    slope_y      <= query_ok ? sat32(80'($signed(ysum[YW-1:16]))) : '0;
    status       <= (typ[7] == REQ_WRITE) ? ST_WRITE : (ok[7] ? ST_OK : ST_OUTSIDE);
  end

endmodule
`default_nettype wire

// ----- rtl/gbi_checker.sv -----
// port-level checker for the grid bilinear interpolation unit
`default_nettype none
module gbi_checker import gbi_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [31:0] interp_value,
  input wire logic [31:0] slope_x,
  input wire logic [31:0] slope_y,
  input wire logic [1:0]  status
);

  // every request transfer yields a result on done
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##8 done)
    else $error("missing result after request transfer");

  // no result without an earlier request transfer
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 8))
    else $error("result without matching request");

  // write and outside results carry zero data
  a_zero_data: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_WRITE || status == ST_OUTSIDE)) |->
      (interp_value == 32'd0 && slope_x == 32'd0 && slope_y == 32'd0))
    else $error("nonzero data on write or outside result");

  // status is a defined code
  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_OK || status == ST_OUTSIDE || status == ST_WRITE))
    else $error("undefined status code");

endmodule

bind grid_bilinear_interpolation_unit gbi_checker u_gbi_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .interp_value (interp_value),
  .slope_x      (slope_x),
  .slope_y      (slope_y),
  .status       (status)
);
`default_nettype wire

// ----- verif/tb.sv -----
// self-checking testbench of the grid bilinear interpolation unit
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import gbi_pkg::*;

  localparam int LATENCY   = 8;
  localparam int LIMIT_CYC = 400000;
  // side of the square corner of the grid that is filled before random queries
  localparam int FILL_DIM  = 16;

  typedef struct packed {
    logic               req;
    logic [5:0]         col;
    logic [5:0]         row;
    logic signed [31:0] sample;
    logic signed [31:0] qx;
    logic signed [31:0] qy;
  } req_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic [1:0]         st;
  } res_t;

  // directed row: request plus an optional typed-in result
  typedef struct packed {
    req_t req;
    logic fixed;
    res_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic req_type = REQ_WRITE;
  logic [5:0] col_index = '0;
  logic [5:0] row_index = '0;
  logic signed [31:0] sample_value = '0;
  logic signed [31:0] query_x = '0;
  logic signed [31:0] query_y = '0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic done;
  logic signed [31:0] interp_value, slope_x, slope_y;
  logic [1:0] status;

  grid_bilinear_interpolation_unit i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
    .col_index(col_index), .row_index(row_index), .sample_value(sample_value),
    .query_x(query_x), .query_y(query_y), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .interp_value(interp_value),
    .slope_x(slope_x), .slope_y(slope_y), .status(status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic signed [63:0] org_x, org_y;
  logic [63:0] inv_x, inv_y, ncols, nrows;
  logic signed [63:0] grid [MAX_COLS*MAX_ROWS];
  bit written [MAX_COLS*MAX_ROWS];

  res_t expected_results [$];
  int errors = 0;
  int cycles = 0;

  function automatic logic signed [63:0] round_q16(logic signed [63:0] v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic logic signed [63:0] clip32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic signed [63:0] scale_slope(logic signed [63:0] a,
                                                     logic [63:0] inv);
    logic [63:0] mag;
    if (a == 0 || inv == 0) return 0;
    mag = a < 0 ? -a : a;
    if (mag > (64'd1 << 62) / inv) return a < 0 ? -64'sd2147483648 : 64'sd2147483647;
    return clip32(round_q16(a * $signed(inv)));
  endfunction

  // map a coordinate to cell index and weight
  function automatic bit find_cell(logic signed [63:0] c, logic signed [63:0] o,
                                   logic [63:0] inv, logic [63:0] used, int lim,
                                   output int idx, output logic signed [63:0] w);
    logic signed [63:0] t;
    logic [63:0] n, i;
    t = (c - o) * $signed(inv);
    n = used < 2 ? 2 : (used > lim ? lim : used);
    idx = 0; w = 0;
    if (t < 0) return 0;
    i = t >> 32;
    if (i >= n) return 0;
    w = (t >> 16) & 64'hffff;
    if (i == n - 1) begin
      i--;
      w += 65536;
    end
    idx = int'(i);
    return 1;
  endfunction

  function automatic res_t predict_bilinear(req_t r);
    res_t o;
    int ix, iy;
    logic signed [63:0] wx, wy, s00, s10, s01, s11, flo, fhi, d;
    o = '0;
    if (r.req == REQ_WRITE) begin
      grid[r.row*MAX_COLS + r.col] = r.sample;
      written[r.row*MAX_COLS + r.col] = 1;
      o.st = ST_WRITE;
    end else if (find_cell(r.qx, org_x, inv_x, ncols, MAX_COLS, ix, wx) &&
                 find_cell(r.qy, org_y, inv_y, nrows, MAX_ROWS, iy, wy)) begin
      s00 = grid[iy*MAX_COLS + ix];
      s10 = grid[iy*MAX_COLS + ix + 1];
      s01 = grid[(iy+1)*MAX_COLS + ix];
      s11 = grid[(iy+1)*MAX_COLS + ix + 1];
      flo = round_q16(s00*(65536-wx) + s10*wx);
      fhi = round_q16(s01*(65536-wx) + s11*wx);
      d   = round_q16((s10-s00)*(65536-wy) + (s11-s01)*wy);
      o.value = 32'(clip32(round_q16(flo*(65536-wy) + fhi*wy)));
      o.sx = 32'(scale_slope(d, inv_x));
      o.sy = 32'(scale_slope(fhi - flo, inv_y));
      o.st = ST_OK;
    end else begin
      o.st = ST_OUTSIDE;
    end
    return o;
  endfunction

  // true when the query reads only written entries (or lies outside)
  function automatic bit reads_written(req_t r);
    int ix, iy;
    logic signed [63:0] wx, wy;
    if (r.req == REQ_WRITE) return 1;
    if (!(find_cell(r.qx, org_x, inv_x, ncols, MAX_COLS, ix, wx) &&
          find_cell(r.qy, org_y, inv_y, nrows, MAX_ROWS, iy, wy))) return 1;
    return written[iy*MAX_COLS+ix] && written[iy*MAX_COLS+ix+1] &&
           written[(iy+1)*MAX_COLS+ix] && written[(iy+1)*MAX_COLS+ix+1];
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    res_t e;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 32'(status), 0);
      end else begin
        e = expected_results.pop_front();
        if (interp_value !== e.value) report_mismatch("interp_value", interp_value, e.value);
        if (slope_x !== e.sx) report_mismatch("slope_x", slope_x, e.sx);
        if (slope_y !== e.sy) report_mismatch("slope_y", slope_y, e.sy);
        if (status !== e.st) report_mismatch("status", 32'(status), 32'(e.st));
      end
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYC) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ORIGIN_X: org_x = $signed(v);
      REG_ORIGIN_Y: org_y = $signed(v);
      REG_INV_X:    inv_x = v & 32'h7fffffff;
      REG_INV_Y:    inv_y = v & 32'h7fffffff;
      REG_COLS:     ncols = v & 32'h7f;
      REG_ROWS:     nrows = v & 32'h7f;
      default: ;
    endcase
  endtask

  // drain pipeline before touching registers
  task automatic wait_idle();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // one transfer with random lead gap; start stays high across back-to-back items
  task automatic send_request(req_t r, bit fixed, res_t want);
    int gap;
    res_t p;
    gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req_type <= r.req;
    col_index <= r.col;
    row_index <= r.row;
    sample_value <= r.sample;
    query_x <= r.qx;
    query_y <= r.qy;
    @(posedge clk);
    while (busy) @(posedge clk);
    p = predict_bilinear(r);
    expected_results.insert(expected_results.size(), fixed ? want : p);
  endtask

  task automatic end_burst();
    start <= 1'b0;
    @(posedge clk);
  endtask

  // random request, well-formed queries mostly inside the filled part of the grid
  function automatic req_t random_request(int shape);
    req_t r;
    logic [63:0] ext, u;
    r.req = REQ_QUERY;
    r.col = 6'($urandom); r.row = 6'($urandom); r.sample = $urandom;
    r.qx = $urandom; r.qy = $urandom;
    if (shape < 30) begin
      r.req = REQ_WRITE;
      if ($urandom_range(0, 4) == 0) r.sample = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      else if ($urandom_range(0, 1)) r.sample = $signed($urandom_range(0, 20 << 16)) - (10 << 16);
    end else if (shape < 90) begin
      // inside: coordinate = origin + u/inv with u in grid units
      ext = ncols < 2 ? 2 : (ncols > MAX_COLS ? MAX_COLS : ncols);
      if (ext > FILL_DIM) ext = FILL_DIM - 1;
      u = {$urandom, $urandom};
      r.qx = 32'(org_x + ((u % (ext << 32)) / (inv_x == 0 ? 64'd1 : inv_x)));
      ext = nrows < 2 ? 2 : (nrows > MAX_ROWS ? MAX_ROWS : nrows);
      if (ext > FILL_DIM) ext = FILL_DIM - 1;
      u = {$urandom, $urandom};
      r.qy = 32'(org_y + ((u % (ext << 32)) / (inv_y == 0 ? 64'd1 : inv_y)));
    end
    return r;
  endfunction

  task automatic random_phase(int count);
    req_t r;
    int n, tries;
    n = 0;
    tries = 0;
    while (n < count && tries < count * 20) begin
      tries++;
      r = random_request($urandom_range(0, 99));
      if (!reads_written(r)) continue;
      send_request(r, 0, '0);
      n++;
    end
    end_burst();
    wait_idle();
  endtask

  // fill the low corner of the store with random samples so queries there are legal
  task automatic fill_grid();
    req_t r;
    int col, row;
    for (int i = 0; i < FILL_DIM*FILL_DIM; i++) begin
      col = i % FILL_DIM;
      row = i / FILL_DIM;
      if (written[row*MAX_COLS + col] && $urandom_range(0, 7) != 0) continue;
      r = '0;
      r.req = REQ_WRITE;
      r.col = 6'(col);
      r.row = 6'(row);
      r.sample = $signed($urandom_range(0, 200 << 16)) - (100 << 16);
      if ($urandom_range(0, 63) == 0) r.sample = $urandom;
      send_request(r, 0, '0);
    end
    end_burst();
    wait_idle();
  endtask

  row_t directed [$];

  task automatic add_row(row_t t);
    directed.insert(directed.size(), t);
  endtask

  function automatic row_t mk(logic rq, logic [5:0] c, logic [5:0] rw, logic [31:0] s,
                              logic [31:0] x, logic [31:0] y, logic fx, res_t want);
    row_t t;
    t.req = '{rq, c, rw, s, x, y};
    t.fixed = fx;
    t.res = want;
    return t;
  endfunction

  initial begin
    org_x = 0; org_y = 0; inv_x = 65536; inv_y = 65536; ncols = 64; nrows = 64;
    foreach (grid[i]) begin
      grid[i] = 0;
      written[i] = 0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table: writes of extremes, edge queries, outside points
    add_row(mk(REQ_WRITE, 0, 0, 32'h7fffffff, 0, 0, 1, '{0, 0, 0, ST_WRITE}));
    add_row(mk(REQ_WRITE, 1, 0, 32'h80000000, 32'hffffffff, 0, 1, '{0, 0, 0, ST_WRITE}));
    add_row(mk(REQ_WRITE, 0, 1, 32'h00010000, 0, 0, 1, '{0, 0, 0, ST_WRITE}));
    add_row(mk(REQ_WRITE, 1, 1, 32'hfffe0000, 0, 0, 1, '{0, 0, 0, ST_WRITE}));
    add_row(mk(REQ_WRITE, 63, 63, 32'h12345678, 0, 0, 1, '{0, 0, 0, ST_WRITE}));
    add_row(mk(REQ_QUERY, 0, 0, 0, 0, 0, 0, '0));
    add_row(mk(REQ_QUERY, 63, 63, 32'hffffffff, 32'h8000, 32'h4000, 0, '0));
    add_row(mk(REQ_QUERY, 0, 0, 0, 32'h0000c000, 32'h0000ffff, 0, '0));
    add_row(mk(REQ_QUERY, 0, 0, 0, 32'hffffffff, 0, 1, '{0, 0, 0, ST_OUTSIDE}));
    add_row(mk(REQ_QUERY, 0, 0, 0, 0, 32'h80000000, 1, '{0, 0, 0, ST_OUTSIDE}));
    add_row(mk(REQ_QUERY, 0, 0, 0, 32'h7fffffff, 0, 1, '{0, 0, 0, ST_OUTSIDE}));
    add_row(mk(REQ_QUERY, 0, 0, 0, 32'h00400000, 0, 1, '{0, 0, 0, ST_OUTSIDE}));
    foreach (directed[i]) send_request(directed[i].req, directed[i].fixed, directed[i].res);
    end_burst();
    wait_idle();

    // filled corner, then several register settings including extremes
    fill_grid();
    random_phase(150);
    write_reg(REG_COLS, 2);
    write_reg(REG_ROWS, 2);
    random_phase(80);
    write_reg(REG_COLS, 0);
    write_reg(REG_ROWS, 127);
    write_reg(REG_INV_X, 32'h7fffffff);
    write_reg(REG_INV_Y, 1);
    random_phase(80);
    write_reg(REG_INV_X, 0);
    write_reg(REG_INV_Y, 32'h00040000);
    write_reg(REG_ORIGIN_X, 32'h80000000);
    write_reg(REG_ORIGIN_Y, 32'h7fffffff);
    write_reg(REG_COLS, 17);
    write_reg(REG_ROWS, 64);
    random_phase(120);
    write_reg(REG_ORIGIN_X, 32'hfff00000);
    write_reg(REG_ORIGIN_Y, 32'h00035000);
    write_reg(REG_INV_X, 32'h00008000);
    write_reg(REG_INV_Y, 32'h00020000);
    write_reg(REG_COLS, 64);
    write_reg(REG_ROWS, 33);
    random_phase(250);
    write_reg(REG_ORIGIN_X, $urandom);
    write_reg(REG_ORIGIN_Y, $urandom);
    write_reg(REG_INV_X, $urandom);
    write_reg(REG_INV_Y, $urandom);
    write_reg(REG_COLS, $urandom_range(2, 64));
    write_reg(REG_ROWS, $urandom_range(2, 64));
    random_phase(250);

    wait_idle();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- files.f -----
rtl/gbi_pkg.sv
rtl/gbi_ram.sv
rtl/grid_bilinear_interpolation_unit.sv
rtl/gbi_checker.sv
verif/tb.sv
